FILE: src/mrhr_pkg.sv
package mrhr_pkg;

    // Sizes of the store, the request and the CAN data field.
    localparam int STORE_BYTES_DEF = 40;
    localparam int REQUEST_LEN     = 8;
    localparam int FRAME_BYTES     = 8;
    localparam int ACK_BYTES       = 6;
    localparam int ID_W            = 29;
    localparam int CFG_W           = 29;

    // Modbus constants.
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ = 8'h03;
    localparam logic [15:0] MAX_QTY   = 16'd125;

    // Reset values of the configuration registers.
    localparam logic [7:0]      DEV_ADDR_RST = 8'h01;
    localparam logic [ID_W-1:0] ACK_ID_RST   = 29'h1802A080;
    localparam logic [ID_W-1:0] DATA1_ID_RST = 29'h1810A080;
    localparam logic [ID_W-1:0] DATA2_ID_RST = 29'h1811A080;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEV_ADDR,
        CFG_ACK_ID,
        CFG_DATA1_ID,
        CFG_DATA2_ID
    } t_cfg_idx;

    // Which CAN id matched.
    typedef enum logic [1:0] {
        KIND_ACK,
        KIND_DATA1,
        KIND_DATA2
    } t_kind;

    // Source of the next reply byte.
    typedef enum logic [2:0] {
        SRC_ADDR,
        SRC_FUNC,
        SRC_CNT,
        SRC_DATA,
        SRC_CRC_LO,
        SRC_CRC_HI
    } t_src;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAN_WR,
        ST_CHECK,
        ST_ADDR,
        ST_FUNC,
        ST_CNT,
        ST_RD,
        ST_DATA,
        ST_CRC_LO,
        ST_CRC_HI
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_serial;
        logic take_frame;
        logic wr_store;
        logic start_reply;
        logic rd_store;
        logic emit;
        t_src src;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic frame_hit;
        logic wr_done;
        logic req_ok;
        logic out_free;
        logic data_last;
    } t_sts;

    // One byte of the reflected CRC-16, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Store position of CAN data byte n for the matched id.
    function automatic logic [7:0] store_pos(input t_kind kind, input logic [2:0] n);
        logic [7:0] p;
        p = 8'd12 + {5'd0, n};
        case (kind)
            KIND_ACK: begin
                case (n)
                    3'd0:    p = 8'h21;
                    3'd1:    p = 8'h23;
                    3'd2:    p = 8'h24;
                    3'd3:    p = 8'h25;
                    3'd4:    p = 8'h26;
                    default: p = 8'h27;
                endcase
            end
            KIND_DATA1: begin
                case (n)
                    3'd0:    p = 8'd1;
                    3'd1:    p = 8'd3;
                    3'd2:    p = 8'd5;
                    3'd3:    p = 8'd7;
                    3'd4:    p = 8'd8;
                    3'd5:    p = 8'd9;
                    3'd6:    p = 8'd10;
                    default: p = 8'd11;
                endcase
            end
            default: p = 8'd12 + {5'd0, n};
        endcase
        return p;
    endfunction

endpackage

FILE: src/mrhr_ram.sv
module mrhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: src/mrhr_ctrl.sv
module mrhr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_mode,
    input  mrhr_pkg::t_sts i_sts,
    output mrhr_pkg::t_cmd o_cmd,
    output logic          o_stall
);
    import mrhr_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        cmd.take_serial = 1'b0;
        cmd.take_frame  = 1'b0;
        cmd.wr_store    = 1'b0;
        cmd.start_reply = 1'b0;
        cmd.rd_store    = 1'b0;
        cmd.emit        = 1'b0;
        cmd.src         = SRC_ADDR;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_mode) begin
                        cmd.take_serial = 1'b1;
                        if (i_sts.fill_last) begin
                            n_state = ST_CHECK;
                        end
                    end else begin
                        cmd.take_frame = 1'b1;
                        if (i_sts.frame_hit) begin
                            n_state = ST_CAN_WR;
                        end
                    end
                end
            end
            ST_CAN_WR: begin
                cmd.wr_store = 1'b1;
                if (i_sts.wr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (i_sts.req_ok) begin
                    cmd.start_reply = 1'b1;
                    n_state         = ST_ADDR;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADDR: begin
                cmd.src = SRC_ADDR;
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_FUNC;
                end
            end
            ST_FUNC: begin
                cmd.src = SRC_FUNC;
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_CNT;
                end
            end
            ST_CNT: begin
                cmd.src = SRC_CNT;
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd_store = 1'b1;
                n_state      = ST_DATA;
            end
            ST_DATA: begin
                cmd.src = SRC_DATA;
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = i_sts.data_last ? ST_CRC_LO : ST_RD;
                end
            end
            ST_CRC_LO: begin
                cmd.src = SRC_CRC_LO;
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_CRC_HI;
                end
            end
            ST_CRC_HI: begin
                cmd.src = SRC_CRC_HI;
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != ST_IDLE);

endmodule

FILE: src/mrhr_dp.sv
module mrhr_dp #(
    parameter int STORE_BYTES = mrhr_pkg::STORE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [mrhr_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [7:0]                  i_serial_byte,
    input  logic [mrhr_pkg::ID_W-1:0]   i_frame_id,
    input  logic [63:0]                 i_frame_payload,
    input  logic                        i_stall,
    input  mrhr_pkg::t_cmd              i_cmd,
    output mrhr_pkg::t_sts              o_sts,
    output logic                        o_valid,
    output logic [7:0]                  o_reply_byte,
    output logic                        o_reply_last
);
    import mrhr_pkg::*;

    localparam int AddrW = $clog2(STORE_BYTES);

    // Configuration registers.
    logic [7:0]      r_dev_addr;
    logic [ID_W-1:0] r_ack_id;
    logic [ID_W-1:0] r_data1_id;
    logic [ID_W-1:0] r_data2_id;

    // Request gathering and CRC.
    logic [7:0]  r_req [REQUEST_LEN];
    logic [2:0]  r_fill;
    logic [15:0] r_crc;

    // CAN frame being written into the store.
    t_kind       r_kind;
    logic [63:0] r_payload;
    logic [2:0]  r_wn;

    // Store bookkeeping and reply progress.
    logic [STORE_BYTES-1:0] r_valid;
    logic                   r_rd_valid;
    logic [AddrW-1:0]       r_addr;
    logic [7:0]             r_left;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [15:0]      start;
    logic [15:0]      qty;
    logic [16:0]      first;
    logic [17:0]      span;
    logic [7:0]       nbytes;
    logic             hit_ack;
    logic             hit_d1;
    logic             hit_d2;
    logic [7:0]       wpos;
    logic             wpos_ok;
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [7:0]       ram_q;
    logic [7:0]       data_byte;
    logic [7:0]       out_byte;
    logic             out_free;
    t_sts             sts;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
            r_ack_id   <= ACK_ID_RST;
            r_data1_id <= DATA1_ID_RST;
            r_data2_id <= DATA2_ID_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEV_ADDR: r_dev_addr <= i_cfg_data[7:0];
                CFG_ACK_ID:   r_ack_id   <= i_cfg_data;
                CFG_DATA1_ID: r_data1_id <= i_cfg_data;
                CFG_DATA2_ID: r_data2_id <= i_cfg_data;
                default:      r_dev_addr <= r_dev_addr;
            endcase
        end
    end

    // Request fields and checks.
    assign start  = {r_req[2], r_req[3]};
    assign qty    = {r_req[4], r_req[5]};
    assign first  = {start, 1'b0};
    assign span   = {1'b0, first} + {1'b0, qty, 1'b0};
    assign nbytes = {qty[6:0], 1'b0};

    // CAN id match, ack first, then data1, then data2.
    assign hit_ack = (i_frame_id == r_ack_id);
    assign hit_d1  = (i_frame_id == r_data1_id);
    assign hit_d2  = (i_frame_id == r_data2_id);

    // Store write position for the current CAN byte.
    assign wpos      = store_pos(r_kind, r_wn);
    assign wpos_ok   = ({1'b0, wpos} < 9'(STORE_BYTES));
    assign ram_we    = i_cmd.wr_store && wpos_ok;
    assign ram_waddr = wpos[AddrW-1:0];

    // Request bytes and running CRC; the CRC register is reused for the reply.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.take_serial) begin
            r_fill <= r_fill + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_serial) begin
            r_req[r_fill] <= i_serial_byte;
            if (r_fill == 3'd0) begin
                r_crc <= crc_byte(CRC_INIT, i_serial_byte);
            end else if (r_fill < 3'(REQUEST_LEN - 2)) begin
                r_crc <= crc_byte(r_crc, i_serial_byte);
            end
        end else if (i_cmd.start_reply) begin
            r_crc <= CRC_INIT;
        end else if (i_cmd.emit && (i_cmd.src != SRC_CRC_LO) && (i_cmd.src != SRC_CRC_HI)) begin
            r_crc <= crc_byte(r_crc, out_byte);
        end
    end

    // CAN frame capture and write counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_frame) begin
            r_payload <= i_frame_payload;
            r_wn      <= 3'd0;
            if (hit_ack) begin
                r_kind <= KIND_ACK;
            end else if (hit_d1) begin
                r_kind <= KIND_DATA1;
            end else begin
                r_kind <= KIND_DATA2;
            end
        end else if (i_cmd.wr_store) begin
            r_wn <= r_wn + 3'd1;
        end
    end

    // Written flags: an unwritten store byte reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[ram_waddr] <= 1'b1;
        end
    end

    mrhr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_payload[{r_wn, 3'b000} +: 8]),
        .i_re    (i_cmd.rd_store),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    // Reply address and byte count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_reply) begin
            r_addr <= first[AddrW-1:0];
            r_left <= nbytes;
        end else if (i_cmd.emit && (i_cmd.src == SRC_DATA)) begin
            r_addr <= r_addr + AddrW'(1);
            r_left <= r_left - 8'd1;
        end
        if (i_cmd.rd_store) begin
            r_rd_valid <= r_valid[r_addr];
        end
    end

    assign data_byte = r_rd_valid ? ram_q : 8'h00;

    // Reply byte selection.
    always_comb begin
        case (i_cmd.src)
            SRC_ADDR:   out_byte = r_dev_addr;
            SRC_FUNC:   out_byte = FUNC_READ;
            SRC_CNT:    out_byte = nbytes;
            SRC_DATA:   out_byte = data_byte;
            SRC_CRC_LO: out_byte = r_crc[7:0];
            SRC_CRC_HI: out_byte = r_crc[15:8];
            default:    out_byte = 8'h00;
        endcase
    end

    // Output register; it frees as soon as its byte is taken.
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= out_byte;
            r_out_last <= (i_cmd.src == SRC_CRC_HI);
        end
    end

    // Status to the controller.
    always_comb begin
        sts.fill_last = (r_fill == 3'(REQUEST_LEN - 1));
        sts.frame_hit = hit_ack || hit_d1 || hit_d2;
        sts.wr_done   = (r_kind == KIND_ACK) ? (r_wn == 3'(ACK_BYTES - 1))
                                             : (r_wn == 3'(FRAME_BYTES - 1));
        sts.req_ok    = (r_req[0] == r_dev_addr)
                     && (r_crc == {r_req[7], r_req[6]})
                     && (r_req[1] == FUNC_READ)
                     && (qty != 16'd0) && (qty <= MAX_QTY)
                     && (span <= 18'(STORE_BYTES));
        sts.out_free  = out_free;
        sts.data_last = (r_left == 8'd1);
    end

    assign o_sts        = sts;
    assign o_valid      = r_out_valid;
    assign o_reply_byte = r_out_byte;
    assign o_reply_last = r_out_last;

endmodule

FILE: src/modbus_rtu_read_holding_responder.sv
// Serial bytes are taken one per cycle while o_stall is low; the eighth completes a request.
// A valid request is checked after the eighth byte and then answered;
// header and CRC bytes go out one per cycle while the output is free, and each data byte
// needs its own read state first, set by the registered read of the store.
// A matched CAN frame keeps the input stalled while its 6 or 8 bytes go into the store, one store write each.
// Reset is synchronous and active low: config to defaults, store reads zero, no clearing pass.
module modbus_rtu_read_holding_responder #(
    parameter int STORE_BYTES = mrhr_pkg::STORE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [mrhr_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic [7:0]                 i_serial_byte,
    input  logic [mrhr_pkg::ID_W-1:0]  i_frame_id,
    input  logic [63:0]                i_frame_payload,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_reply_byte,
    output logic                       o_reply_last
);
    import mrhr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mrhr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    mrhr_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_serial_byte   (i_serial_byte),
        .i_frame_id      (i_frame_id),
        .i_frame_payload (i_frame_payload),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_reply_byte    (o_reply_byte),
        .o_reply_last    (o_reply_last)
    );

endmodule

FILE: src/mrhr_checker.sv
module mrhr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_reply_byte,
    input logic        o_reply_last
);

    // After reset the block is idle with nothing to send.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

    // A stalled reply byte holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_reply_byte) && $stable(o_reply_last)))
        else $error("stalled reply byte changed");

    // Reply bytes appear only while a request is being answered.
    a_reply_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("reply byte appeared while idle");

    // When the final CRC byte is taken while the block is idle, no byte follows at once.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reply_last && !i_stall && !o_stall) |=> !o_valid)
        else $error("reply byte right after the final CRC byte");

endmodule

bind modbus_rtu_read_holding_responder mrhr_checker u_mrhr_checker (.*);

FILE: tb/sv/tb_modbus_rtu_read_holding_responder.sv
module tb_modbus_rtu_read_holding_responder;
    import mrhr_pkg::*;

    localparam int STORE      = STORE_BYTES_DEF;
    localparam int REG_WORDS  = STORE / 2;
    localparam int SETTLE     = 24;
    localparam int LONG_HOLD  = 300;
    localparam int QUIET_MAX  = 5000;

    // Store slots for the bytes of ack and data-1 frames, byte 0 lowest.
    localparam logic [47:0] ACK_SLOTS   = {8'h27, 8'h26, 8'h25, 8'h24, 8'h23, 8'h21};
    localparam logic [63:0] DATA1_SLOTS = {8'd11, 8'd10, 8'd9, 8'd8, 8'd7, 8'd5, 8'd3, 8'd1};

    typedef struct {
        logic            mode;
        logic [7:0]      ser;
        logic [ID_W-1:0] fid;
        logic [63:0]     pay;
    } t_rx_item;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_reply;

    logic               i_clk       = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    t_cfg_idx           cfg_idx     = CFG_DEV_ADDR;
    logic [CFG_W-1:0]   cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_mode     = 1'b0;
    logic [7:0]         in_serial   = '0;
    logic [ID_W-1:0]    in_id       = '0;
    logic [63:0]        in_payload  = '0;
    logic               out_stall   = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [7:0]         o_reply_byte;
    logic               o_reply_last;

    // Slave state as the checker sees it.
    logic [7:0]         slave_addr;
    logic [ID_W-1:0]    id_ack;
    logic [ID_W-1:0]    id_data1;
    logic [ID_W-1:0]    id_data2;
    logic [7:0]         query [8];
    logic [2:0]         query_fill;
    logic [7:0]         regs [STORE];

    t_rx_item           pending_requests [$];
    t_reply             reply_due [$];
    t_rx_item           pick_item;
    t_reply             want_reply;
    int                 gen_fill    = 0;
    int                 errors      = 0;
    int                 gap_left    = 0;
    int                 burst_left  = 0;
    int                 seg_left    = 0;
    int                 stall_pct   = 0;
    int                 hold_cycles = 0;
    bit                 hold_done   = 1'b0;
    bit                 pressure_on = 1'b0;

    always #5 i_clk = ~i_clk;

    modbus_rtu_read_holding_responder #(
        .STORE_BYTES(STORE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_mode         (in_mode),
        .i_serial_byte  (in_serial),
        .i_frame_id     (in_id),
        .i_frame_payload(in_payload),
        .o_valid        (o_valid),
        .i_stall        (out_stall),
        .o_reply_byte   (o_reply_byte),
        .o_reply_last   (o_reply_last)
    );

    // Reflected CRC-16, fed one data bit at a time.
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Checks a complete query and queues the reply bytes it calls for.
    function automatic void answer_query();
        logic [15:0] crc;
        int unsigned start;
        int unsigned qty;
        int unsigned first;
        int unsigned nbytes;
        logic [7:0]  msg [$];
        t_reply      r;
        if (query[0] != slave_addr) begin
            return;
        end
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = crc16_step(crc, query[i]);
        end
        if (crc != {query[7], query[6]} || query[1] != FUNC_READ) begin
            return;
        end
        start = 32'({query[2], query[3]});
        qty   = 32'({query[4], query[5]});
        if (qty < 1 || qty > MAX_QTY) begin
            return;
        end
        first  = start * 2;
        nbytes = qty * 2;
        if (first + nbytes > STORE) begin
            return;
        end
        msg.push_back(slave_addr);
        msg.push_back(FUNC_READ);
        msg.push_back(nbytes[7:0]);
        for (int k = 0; k < nbytes; k++) begin
            msg.push_back(regs[first + k]);
        end
        crc = CRC_INIT;
        foreach (msg[i]) begin
            crc = crc16_step(crc, msg[i]);
        end
        msg.push_back(crc[7:0]);
        msg.push_back(crc[15:8]);
        foreach (msg[i]) begin
            r.value = msg[i];
            r.last  = (i == msg.size() - 1);
            reply_due.push_back(r);
        end
    endfunction

    // Applies one accepted request to the slave state.
    function automatic void serve_item(input logic mode, input logic [7:0] ser,
                                       input logic [ID_W-1:0] fid, input logic [63:0] pay);
        int pos;
        if (!mode) begin
            query[query_fill] = ser;
            query_fill = query_fill + 3'd1;
            if (query_fill == 3'd0) begin
                answer_query();
            end
        end else if (fid == id_ack) begin
            for (int n = 0; n < 6; n++) begin
                pos = int'(ACK_SLOTS[8*n +: 8]);
                if (pos < STORE) begin
                    regs[pos] = pay[8*n +: 8];
                end
            end
        end else if (fid == id_data1) begin
            for (int n = 0; n < 8; n++) begin
                pos = int'(DATA1_SLOTS[8*n +: 8]);
                if (pos < STORE) begin
                    regs[pos] = pay[8*n +: 8];
                end
            end
        end else if (fid == id_data2) begin
            for (int n = 0; n < 8; n++) begin
                if (12 + n < STORE) begin
                    regs[12 + n] = pay[8*n +: 8];
                end
            end
        end
    endfunction

    // Serial byte; the frame fields carry junk that must be ignored.
    function automatic void push_serial(input logic [7:0] b);
        t_rx_item it;
        it.mode = 1'b0;
        it.ser  = b;
        it.fid  = ID_W'($urandom);
        it.pay  = {$urandom, $urandom};
        pending_requests.push_back(it);
        gen_fill = (gen_fill + 1) % 8;
    endfunction

    function automatic void push_frame(input logic [ID_W-1:0] fid, input logic [63:0] pay);
        t_rx_item it;
        it.mode = 1'b1;
        it.ser  = 8'($urandom);
        it.fid  = fid;
        it.pay  = pay;
        pending_requests.push_back(it);
    endfunction

    // Queues an 8-byte query, first padding out any partial one.
    function automatic void push_query(input logic [7:0] addr, input logic [7:0] func,
                                       input logic [15:0] start, input logic [15:0] qty,
                                       input bit good_crc);
        logic [7:0]  b [8];
        logic [15:0] crc;
        while (gen_fill != 0) begin
            push_serial(8'($urandom));
        end
        b[0] = addr;
        b[1] = func;
        b[2] = start[15:8];
        b[3] = start[7:0];
        b[4] = qty[15:8];
        b[5] = qty[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            crc = crc16_step(crc, b[i]);
        end
        b[6] = crc[7:0];
        b[7] = crc[15:8];
        if (!good_crc) begin
            b[6 + $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
        end
        for (int i = 0; i < 8; i++) begin
            push_serial(b[i]);
        end
    endfunction

    // Mostly well-formed queries and matching frames, with some noise mixed in.
    function automatic void queue_phase(input int n);
        int          base;
        int unsigned r;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [15:0] start;
        logic [15:0] qty;
        logic [ID_W-1:0] fid;
        base = pending_requests.size();
        while (pending_requests.size() - base < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                addr  = ($urandom_range(9) == 0) ? 8'($urandom) : slave_addr;
                func  = ($urandom_range(9) == 0) ? 8'($urandom) : FUNC_READ;
                qty   = 16'($urandom_range(REG_WORDS, 1));
                start = 16'($urandom_range(REG_WORDS - qty, 0));
                case ($urandom_range(19))
                    0: qty = 16'd0;
                    1: qty = ($urandom_range(1) == 0) ? 16'd126 : 16'hFFFF;
                    2: begin
                        start = 16'hFFFF;
                        qty   = 16'd1;
                    end
                    3: start = 16'(REG_WORDS - qty + 1);
                    4: begin
                        start = 16'd0;
                        qty   = MAX_QTY;
                    end
                    default: ;
                endcase
                push_query(addr, func, start, qty, $urandom_range(9) != 0);
            end else if (r < 80) begin
                case ($urandom_range(2))
                    0:       fid = id_ack;
                    1:       fid = id_data1;
                    default: fid = id_data2;
                endcase
                push_frame(fid, {$urandom, $urandom});
            end else if (r < 90) begin
                fid = ID_W'($urandom);
                push_frame(fid, {$urandom, $urandom});
            end else begin
                repeat ($urandom_range(7, 1)) begin
                    push_serial(8'($urandom));
                end
            end
        end
    endfunction

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_DEV_ADDR: slave_addr = val[7:0];
            CFG_ACK_ID:   id_ack     = val;
            CFG_DATA1_ID: id_data1   = val;
            default:      id_data2   = val;
        endcase
    endtask

    // Waits until every request is taken and every reply byte seen, then lets
    // a frame still being written into the store finish.
    task automatic drain_and_settle();
        while (pending_requests.size() != 0 || in_valid || reply_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Sender: bursts of requests separated by random gaps.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                pick_item = pending_requests.pop_front();
                in_mode    <= pick_item.mode;
                in_serial  <= pick_item.ser;
                in_id      <= pick_item.fid;
                in_payload <= pick_item.pay;
                in_valid   <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20)
                                                          : $urandom_range(12, 0);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off when the pressure phase starts, otherwise
    // segments with their own stall density, some with none at all.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (pressure_on && !hold_done) begin
            out_stall <= 1'b1;
            hold_cycles++;
            if (hold_cycles >= LONG_HOLD) begin
                hold_done = 1'b1;
            end
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(80, 10);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Prediction on each accepted request, comparison on each reply byte.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && !o_stall) begin
                serve_item(in_mode, in_serial, in_id, in_payload);
            end
            if (o_valid && !out_stall) begin
                if (reply_due.size() == 0) begin
                    errors++;
                    $display("%0t: reply byte %02h with none expected", $time, o_reply_byte);
                end else begin
                    want_reply = reply_due.pop_front();
                    if (o_reply_byte !== want_reply.value) begin
                        errors++;
                        $display("%0t: reply_byte expected %02h, got %02h",
                                 $time, want_reply.value, o_reply_byte);
                    end
                    if (o_reply_last !== want_reply.last) begin
                        errors++;
                        $display("%0t: reply_last expected %0b, got %0b",
                                 $time, want_reply.last, o_reply_last);
                    end
                end
            end
        end
    end

    // Ends the run if nothing moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if ((in_valid && !o_stall) || (o_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [ID_W-1:0] shared_id;
        int              qty;

        slave_addr = DEV_ADDR_RST;
        id_ack     = ACK_ID_RST;
        id_data1   = DATA1_ID_RST;
        id_data2   = DATA2_ID_RST;
        query_fill = 3'd0;
        foreach (query[i]) begin
            query[i] = 8'h00;
        end
        foreach (regs[i]) begin
            regs[i] = 8'h00;
        end

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: each frame kind, an unmatched frame, a full-store read and
        // a read of the last register, all at reset settings.
        push_frame(id_ack, 64'hFFFF_FFFF_FFFF_FFFF);
        push_frame(id_data1, 64'h0123_4567_89AB_CDEF);
        push_frame(id_data2, 64'h8000_0000_0000_0001);
        push_frame(29'h1FFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A);
        push_query(slave_addr, FUNC_READ, 16'd0, 16'(REG_WORDS), 1'b1);
        push_query(slave_addr, FUNC_READ, 16'(REG_WORDS - 1), 16'd1, 1'b1);
        drain_and_settle();

        // Extreme settings.
        write_cfg(CFG_DEV_ADDR, 29'hFF);
        write_cfg(CFG_ACK_ID, 29'h1FFF_FFFF);
        write_cfg(CFG_DATA1_ID, 29'h0);
        write_cfg(CFG_DATA2_ID, 29'($urandom));
        queue_phase(75);
        drain_and_settle();

        // All ids equal: the ack mapping must win.
        shared_id = ID_W'($urandom);
        write_cfg(CFG_DEV_ADDR, 29'h0);
        write_cfg(CFG_ACK_ID, shared_id);
        write_cfg(CFG_DATA1_ID, shared_id);
        write_cfg(CFG_DATA2_ID, shared_id);
        queue_phase(75);
        drain_and_settle();

        // Data ids equal: the data-1 mapping must win.
        shared_id = ID_W'($urandom);
        write_cfg(CFG_DEV_ADDR, 29'($urandom_range(255)));
        write_cfg(CFG_ACK_ID, 29'($urandom));
        write_cfg(CFG_DATA1_ID, shared_id);
        write_cfg(CFG_DATA2_ID, shared_id);
        queue_phase(75);
        drain_and_settle();

        // Back-pressure: the receiver holds off while long reads keep coming.
        write_cfg(CFG_DEV_ADDR, 29'($urandom_range(255)));
        write_cfg(CFG_ACK_ID, ACK_ID_RST);
        write_cfg(CFG_DATA1_ID, DATA1_ID_RST);
        write_cfg(CFG_DATA2_ID, DATA2_ID_RST);
        push_frame(id_data1, {$urandom, $urandom});
        push_frame(id_data2, {$urandom, $urandom});
        repeat (12) begin
            qty = $urandom_range(REG_WORDS, 8);
            push_query(slave_addr, FUNC_READ, 16'($urandom_range(REG_WORDS - qty, 0)),
                       16'(qty), 1'b1);
        end
        pressure_on = 1'b1;
        drain_and_settle();

        // Fully random settings.
        write_cfg(CFG_DEV_ADDR, 29'($urandom_range(255)));
        write_cfg(CFG_ACK_ID, 29'($urandom));
        write_cfg(CFG_DATA1_ID, 29'($urandom));
        write_cfg(CFG_DATA2_ID, 29'($urandom));
        queue_phase(80);
        drain_and_settle();

        if (reply_due.size() != 0) begin
            errors++;
            $display("%0t: %0d reply bytes never arrived", $time, reply_due.size());
        end
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
